### rtl/core/tras_pkg.sv
`timescale 1ns / 1ps

package tras_pkg;

    // Request operations
    typedef enum logic [2:0] {
        OP_RD01    = 3'd0,
        OP_RD23    = 3'd1,
        OP_RDREG   = 3'd2,
        OP_RAM_WR  = 3'd3,
        OP_EE_WR   = 3'd4,
        OP_WR32    = 3'd5,
        OP_NORMAL  = 3'd6,
        OP_UNKNOWN = 3'd7
    } op_t;

    typedef enum logic {
        FUNC_REQUEST  = 1'b0,
        FUNC_RESPONSE = 1'b1
    } func_t;

    typedef enum logic {
        KIND_ACCESS = 1'b0,
        KIND_DONE   = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BUS_ERR = 2'd1,
        ST_BAD_OP  = 2'd2
    } status_t;

    localparam logic [6:0]  CODE_READ    = 7'd3;
    localparam logic [6:0]  CODE_WRITE   = 7'd6;
    localparam logic [15:0] READ_SELECT  = 16'h0080;
    localparam logic [15:0] WRITE_SELECT = 16'h00C0;
    localparam logic [15:0] LOCK_REG     = 16'd31;
    localparam logic [15:0] UNLOCK_CODE  = 16'h1235;
    localparam logic [15:0] IMAGE_RESET  = 16'h0800;
    localparam logic [6:0]  LAST_RD_CODE = 7'd4;

    typedef struct packed {
        func_t       func;
        op_t         op;
        logic [15:0] base_address;
        logic [5:0]  reg_number;
        logic [31:0] write_value;
        logic [6:0]  normal_code;
        logic [6:0]  normal_words;
        logic [31:0] request_tag;
        logic        resp_error;
        logic [15:0] resp_word;
    } in_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [6:0]  bus_code;
        logic [15:0] bus_address;
        logic [15:0] bus_word;
        logic [6:0]  bus_words;
        status_t     done_status;
        logic [15:0] done_low;
        logic [15:0] done_high;
        logic [31:0] done_tag;
    } out_item_t;

    // Sequencer context carried between beats
    typedef struct packed {
        logic        busy;
        op_t         op;
        logic [3:0]  step;
        logic [15:0] saved;
        logic [15:0] base;
        logic [5:0]  regn;
        logic [31:0] value;
        logic [15:0] first;
        logic [31:0] tag;
    } ctx_t;

    function automatic out_item_t make_access(logic [6:0] code, logic [15:0] addr,
                                              logic [15:0] word, logic [6:0] words);
        out_item_t o;
        o             = '0;
        o.kind        = KIND_ACCESS;
        o.bus_code    = code;
        o.bus_address = addr;
        o.bus_word    = word;
        o.bus_words   = words;
        o.done_status = ST_OK;
        return o;
    endfunction

    function automatic out_item_t make_done(status_t st, logic [15:0] low,
                                            logic [15:0] high, logic [31:0] tag);
        out_item_t o;
        o             = '0;
        o.kind        = KIND_DONE;
        o.bus_words   = 7'd1;
        o.done_status = st;
        o.done_low    = low;
        o.done_high   = high;
        o.done_tag    = tag;
        return o;
    endfunction

endpackage

### rtl/core/tras_ifs.sv
`timescale 1ns / 1ps

interface tras_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [2:0]  op;
    logic [15:0] base_address;
    logic [5:0]  reg_number;
    logic [31:0] write_value;
    logic [6:0]  normal_code;
    logic [6:0]  normal_words;
    logic [31:0] request_tag;
    logic        resp_error;
    logic [15:0] resp_word;

    modport source (output valid, func, op, base_address, reg_number, write_value,
                    normal_code, normal_words, request_tag, resp_error, resp_word,
                    input ready);
    modport sink (input valid, func, op, base_address, reg_number, write_value,
                  normal_code, normal_words, request_tag, resp_error, resp_word,
                  output ready);
endinterface

interface tras_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [6:0]  bus_code;
    logic [15:0] bus_address;
    logic [15:0] bus_word;
    logic [6:0]  bus_words;
    logic [1:0]  done_status;
    logic [15:0] done_low;
    logic [15:0] done_high;
    logic [31:0] done_tag;

    modport source (output valid, kind, bus_code, bus_address, bus_word, bus_words,
                    done_status, done_low, done_high, done_tag,
                    input ready);
    modport sink (input valid, kind, bus_code, bus_address, bus_word, bus_words,
                  done_status, done_low, done_high, done_tag,
                  output ready);
endinterface

interface tras_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

### rtl/core/tras_in_stage.sv
`timescale 1ns / 1ps

module tras_in_stage
(
    input  logic                clk,
    input  logic                rst_n,
    tras_in_if.sink             item,
    input  logic                advance_ok,
    output logic                held_vld,
    output tras_pkg::in_item_t  held_item
);

    logic               vld_reg;
    logic               vld_next;
    tras_pkg::in_item_t data_reg;
    logic               take;

    assign item.ready = !vld_reg || advance_ok;
    assign take       = item.valid && item.ready;

    always_comb
    begin
        if (take)
        begin
            vld_next = 1'b1;
        end
        else if (advance_ok)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg.func         <= tras_pkg::func_t'(item.func);
            data_reg.op           <= tras_pkg::op_t'(item.op);
            data_reg.base_address <= item.base_address;
            data_reg.reg_number   <= item.reg_number;
            data_reg.write_value  <= item.write_value;
            data_reg.normal_code  <= item.normal_code;
            data_reg.normal_words <= item.normal_words;
            data_reg.request_tag  <= item.request_tag;
            data_reg.resp_error   <= item.resp_error;
            data_reg.resp_word    <= item.resp_word;
        end
    end

    assign held_vld  = vld_reg;
    assign held_item = data_reg;

endmodule

### rtl/core/tras_step.sv
`timescale 1ns / 1ps

module tras_step
(
    input  tras_pkg::in_item_t  itm,
    input  tras_pkg::ctx_t      ctx,
    input  logic [15:0]         offset,
    output tras_pkg::ctx_t      ctx_out,
    output logic                has_res,
    output tras_pkg::out_item_t res
);

    // Sequence length in beats per op
    function automatic logic [3:0] seq_len(tras_pkg::op_t op);
        logic [3:0] n;
        unique case (op)
            tras_pkg::OP_RD01, tras_pkg::OP_RD23:    n = 4'd8;
            tras_pkg::OP_RDREG, tras_pkg::OP_RAM_WR: n = 4'd4;
            tras_pkg::OP_EE_WR, tras_pkg::OP_WR32:   n = 4'd9;
            default:                                 n = 4'd1;
        endcase
        return n;
    endfunction

    // Bus access for the current step of the context
    function automatic tras_pkg::out_item_t issue(tras_pkg::ctx_t c, logic [15:0] offs);
        logic [15:0]         w;
        logic [15:0]         d;
        logic [15:0]         inp;
        logic                upper;
        logic [6:0]          r;
        logic [15:0]         v;
        logic [15:0]         sel;
        tras_pkg::out_item_t o;
        w     = c.base + offs;
        d     = w + 16'd1;
        inp   = c.base + 16'd1;
        upper = c.step[3] | c.step[2];
        r     = {1'b0, c.regn};
        v     = c.value[15:0];
        unique case (c.op)
            tras_pkg::OP_RD01, tras_pkg::OP_RD23, tras_pkg::OP_RDREG:
            begin
                if (c.op == tras_pkg::OP_RD01)
                begin
                    r = {6'd0, upper};
                end
                else if (c.op == tras_pkg::OP_RD23)
                begin
                    r = 7'd2 + {6'd0, upper};
                end
                sel = tras_pkg::READ_SELECT + {9'd0, r};
                unique case (c.step[1:0])
                    2'd0:    o = tras_pkg::make_access(tras_pkg::CODE_READ, w, 16'd0, 7'd1);
                    2'd1:    o = tras_pkg::make_access(tras_pkg::CODE_WRITE, w, sel, 7'd1);
                    2'd2:    o = tras_pkg::make_access(tras_pkg::CODE_READ, inp, 16'd0, 7'd1);
                    default: o = tras_pkg::make_access(tras_pkg::CODE_WRITE, w, c.saved, 7'd1);
                endcase
            end
            tras_pkg::OP_RAM_WR, tras_pkg::OP_WR32:
            begin
                if (c.op == tras_pkg::OP_WR32)
                begin
                    r = r + {6'd0, upper};
                    v = upper ? c.value[31:16] : c.value[15:0];
                end
                sel = tras_pkg::WRITE_SELECT + {9'd0, r};
                if (c.op == tras_pkg::OP_WR32 && c.step[3])
                begin
                    // trailing clear of the data-out word
                    o = tras_pkg::make_access(tras_pkg::CODE_WRITE, d, 16'd0, 7'd1);
                end
                else
                begin
                    unique case (c.step[1:0])
                        2'd0:    o = tras_pkg::make_access(tras_pkg::CODE_READ, w, 16'd0, 7'd1);
                        2'd1:    o = tras_pkg::make_access(tras_pkg::CODE_WRITE, w, sel, 7'd1);
                        2'd2:    o = tras_pkg::make_access(tras_pkg::CODE_WRITE, d, v, 7'd1);
                        default: o = tras_pkg::make_access(tras_pkg::CODE_WRITE, w, c.saved,
                                                           7'd1);
                    endcase
                end
            end
            default:
            begin
                // EEPROM write: unlock, write, relock, restore
                sel = tras_pkg::WRITE_SELECT + {9'd0, r};
                unique case (c.step)
                    4'd0: o = tras_pkg::make_access(tras_pkg::CODE_READ, w, 16'd0, 7'd1);
                    4'd1, 4'd5:
                        o = tras_pkg::make_access(tras_pkg::CODE_WRITE, w,
                                                  tras_pkg::WRITE_SELECT + tras_pkg::LOCK_REG,
                                                  7'd1);
                    4'd2: o = tras_pkg::make_access(tras_pkg::CODE_WRITE, d,
                                                    tras_pkg::UNLOCK_CODE, 7'd1);
                    4'd3: o = tras_pkg::make_access(tras_pkg::CODE_WRITE, w, sel, 7'd1);
                    4'd4: o = tras_pkg::make_access(tras_pkg::CODE_WRITE, d, v, 7'd1);
                    4'd6: o = tras_pkg::make_access(tras_pkg::CODE_WRITE, d, 16'd0, 7'd1);
                    4'd7: o = tras_pkg::make_access(tras_pkg::CODE_WRITE, w, 16'd0, 7'd1);
                    default: o = tras_pkg::make_access(tras_pkg::CODE_WRITE, w, c.saved, 7'd1);
                endcase
            end
        endcase
        return o;
    endfunction

    tras_pkg::ctx_t c2;
    logic           is_read_op;
    logic           is_pair_op;
    logic [15:0]    err_low;
    logic [15:0]    pass_word;

    assign is_pair_op = (ctx.op == tras_pkg::OP_RD01) || (ctx.op == tras_pkg::OP_RD23);
    assign is_read_op = is_pair_op || (ctx.op == tras_pkg::OP_RDREG);
    assign err_low    = (is_pair_op && (ctx.step[3] | ctx.step[2])) ? ctx.first : 16'd0;
    assign pass_word  = (ctx.value <= {25'd0, tras_pkg::LAST_RD_CODE}) ? itm.resp_word : 16'd0;

    always_comb
    begin
        c2      = ctx;
        ctx_out = ctx;
        has_res = 1'b0;
        res     = '0;
        if (itm.func == tras_pkg::FUNC_REQUEST)
        begin
            if (!ctx.busy)
            begin
                has_res = 1'b1;
                if (itm.op == tras_pkg::OP_UNKNOWN)
                begin
                    res = tras_pkg::make_done(tras_pkg::ST_BAD_OP, 16'd0, 16'd0,
                                              itm.request_tag);
                end
                else
                begin
                    c2.busy  = 1'b1;
                    c2.op    = itm.op;
                    c2.step  = 4'd0;
                    c2.saved = 16'd0;
                    c2.base  = itm.base_address;
                    c2.regn  = itm.reg_number;
                    c2.value = itm.write_value;
                    c2.first = 16'd0;
                    c2.tag   = itm.request_tag;
                    if (itm.op == tras_pkg::OP_NORMAL)
                    begin
                        res = tras_pkg::make_access(itm.normal_code, itm.base_address,
                                  (itm.normal_code > tras_pkg::LAST_RD_CODE) ?
                                  itm.write_value[15:0] : 16'd0,
                                  itm.normal_words);
                        c2.value = {25'd0, itm.normal_code};
                    end
                    else
                    begin
                        res = issue(c2, offset);
                    end
                    ctx_out = c2;
                end
            end
        end
        else if (ctx.busy)
        begin
            has_res = 1'b1;
            if (itm.resp_error)
            begin
                c2.busy = 1'b0;
                res     = tras_pkg::make_done(tras_pkg::ST_BUS_ERR, err_low, 16'd0, ctx.tag);
            end
            else if (ctx.op == tras_pkg::OP_NORMAL)
            begin
                c2.busy = 1'b0;
                res     = tras_pkg::make_done(tras_pkg::ST_OK, pass_word, 16'd0, ctx.tag);
            end
            else
            begin
                if (ctx.step[1:0] == 2'd0 && !ctx.step[3] &&
                    (ctx.op != tras_pkg::OP_EE_WR || ctx.step == 4'd0))
                begin
                    c2.saved = itm.resp_word;
                end
                if (is_read_op && ctx.step[1:0] == 2'd2)
                begin
                    if (ctx.step[3] | ctx.step[2])
                    begin
                        c2.value = {16'd0, itm.resp_word};
                    end
                    else
                    begin
                        c2.first = itm.resp_word;
                    end
                end
                c2.step = ctx.step + 4'd1;
                if (c2.step >= seq_len(ctx.op))
                begin
                    c2.busy = 1'b0;
                    if (is_pair_op)
                    begin
                        res = tras_pkg::make_done(tras_pkg::ST_OK, c2.first, c2.value[15:0],
                                                  ctx.tag);
                    end
                    else if (ctx.op == tras_pkg::OP_RDREG)
                    begin
                        res = tras_pkg::make_done(tras_pkg::ST_OK, c2.first, 16'd0, ctx.tag);
                    end
                    else
                    begin
                        res = tras_pkg::make_done(tras_pkg::ST_OK, 16'd0, 16'd0, ctx.tag);
                    end
                end
                else
                begin
                    res = issue(c2, offset);
                end
            end
            ctx_out = c2;
        end
    end

endmodule

### rtl/core/tras_out_stage.sv
`timescale 1ns / 1ps

module tras_out_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  tras_pkg::out_item_t load_item,
    output logic                can_load,
    tras_out_if.source          result
);

    logic                vld_reg;
    logic                vld_next;
    tras_pkg::out_item_t data_reg;

    assign can_load = !vld_reg || result.ready;

    always_comb
    begin
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (result.ready)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_item;
        end
    end

    assign result.valid       = vld_reg;
    assign result.kind        = data_reg.kind;
    assign result.bus_code    = data_reg.bus_code;
    assign result.bus_address = data_reg.bus_address;
    assign result.bus_word    = data_reg.bus_word;
    assign result.bus_words   = data_reg.bus_words;
    assign result.done_status = data_reg.done_status;
    assign result.done_low    = data_reg.done_low;
    assign result.done_high   = data_reg.done_high;
    assign result.done_tag    = data_reg.done_tag;

endmodule

### rtl/core/terminal_register_access_sequencer_unit.sv
`timescale 1ns / 1ps

// Terminal register access sequencer. A request beat on "item" (func = 0)
// names a terminal channel, an operation and its operands; the block answers
// with one bus access command on "result", or with a completion if the op
// is unknown. Each bus response beat (func = 1) is answered with the next
// access or, after the last step or the first failed access, with a
// completion carrying the request tag. Requests while a sequence is open and
// responses while idle are dropped without a result. Every accepted beat
// lands in an input register; one pass of step decode then updates the
// sequencer context and loads the output register once it can take the
// result, and a beat can be accepted every cycle while the output side keeps
// taking results. The image offset register (reset 0x800) is written through
// "cfg" and must only be changed while no sequence is open.

module terminal_register_access_sequencer_unit
(
    input  logic        clk,
    input  logic        rst_n,
    tras_in_if.sink     item,
    tras_out_if.source  result,
    tras_cfg_if.sink    cfg
);

    // Image offset register, always writable
    logic [15:0] offset_reg;
    logic [15:0] offset_next;

    assign cfg.ready   = 1'b1;
    assign offset_next = (cfg.valid && cfg.ready) ? cfg.data : offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= tras_pkg::IMAGE_RESET;
        end
        else
        begin
            offset_reg <= offset_next;
        end
    end

    // Input register
    logic               held_vld;
    tras_pkg::in_item_t held_item;
    logic               can_load;

    tras_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .advance_ok (can_load),
        .held_vld   (held_vld),
        .held_item  (held_item)
    );

    // Step decode: context plus beat gives next context and result
    tras_pkg::ctx_t      ctx_reg;
    tras_pkg::ctx_t      ctx_next;
    tras_pkg::ctx_t      step_ctx;
    logic                step_has;
    tras_pkg::out_item_t step_res;
    logic                fire;

    tras_step u_step
    (
        .itm     (held_item),
        .ctx     (ctx_reg),
        .offset  (offset_reg),
        .ctx_out (step_ctx),
        .has_res (step_has),
        .res     (step_res)
    );

    // A beat is consumed only when the output register can take its result
    assign fire     = held_vld && can_load;
    assign ctx_next = fire ? step_ctx : ctx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_reg <= '0;
        end
        else
        begin
            ctx_reg <= ctx_next;
        end
    end

    // Output register
    tras_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire && step_has),
        .load_item (step_res),
        .can_load  (can_load),
        .result    (result)
    );

    // An open sequence never runs past its longest length
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctx_reg.busy |-> ctx_reg.step <= 4'd8)
        else $error("sequencer step out of range");

    // The unknown op completes at once and never opens a sequence
    a_no_bad_op: assert property (@(posedge clk) disable iff (!rst_n)
        ctx_reg.busy |-> ctx_reg.op != tras_pkg::OP_UNKNOWN)
        else $error("unknown op held open");

    // Passthrough is a single access
    a_normal_step: assert property (@(posedge clk) disable iff (!rst_n)
        (ctx_reg.busy && ctx_reg.op == tras_pkg::OP_NORMAL) |-> ctx_reg.step == 4'd0)
        else $error("passthrough advanced its step");

    // A completion closes the sequence
    a_done_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && step_has && step_res.kind == tras_pkg::KIND_DONE) |=> !ctx_reg.busy)
        else $error("sequence still open after completion");

    // A bus command always leaves a sequence open
    a_access_opens: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && step_has && step_res.kind == tras_pkg::KIND_ACCESS) |=> ctx_reg.busy)
        else $error("bus command issued with no open sequence");

endmodule
